// ===== rtl/regex_dot_star_matcher_macros.svh =====
// Assertion macros shared by the matcher RTL.
// Included by the files that carry concurrent checks; needs no package.
`ifndef REGEX_DOT_STAR_MATCHER_MACROS_SVH
`define REGEX_DOT_STAR_MATCHER_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define RDSM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define RDSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RDSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rdsm_pkg.sv =====
// Shared types and constants of the dot-star matcher.
// Used by rdsm_front, rdsm_back and the top level; depends on nothing.
package rdsm_pkg;

	// Stream widths
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 8;

	// Command codes on s_axis_tuser
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_START  = 2'd2;
	localparam logic [1:0] CMD_TEXT   = 2'd3;

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_START  = 2'd2,
		OP_TEXT   = 2'd3
	} op_kind_t;

	// One classified item as it travels to the back end
	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  symbol;
		logic        any_byte;
		logic        repeat_req;
	} op_t;

endpackage

// ===== rtl/rdsm_front.sv =====
// Front end: decodes incoming items and queues them for the back end.
// Depends on rdsm_pkg and the assertion macros header.
`include "regex_dot_star_matcher_macros.svh"

module rdsm_front import rdsm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] symbol, [8] any_byte, [9] repeat_req
	input  logic [S_TUSER_W-1:0] s_axis_tuser,  // [1:0] command
	output op_t                  op,
	output logic                 op_valid,
	input  logic                 op_pop
);

	op_t            op_in;
	op_t            q_mem [QDEPTH];
	logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           push;

	// Classify the item; pattern flags only travel with appends
	always_comb begin
		op_in.symbol     = s_axis_tdata[7:0];
		op_in.any_byte   = 1'b0;
		op_in.repeat_req = 1'b0;
		unique case (s_axis_tuser)
			CMD_CLEAR:  op_in.kind = OP_CLEAR;
			CMD_APPEND: begin
				op_in.kind       = OP_APPEND;
				op_in.any_byte   = s_axis_tdata[8];
				op_in.repeat_req = s_axis_tdata[9];
			end
			CMD_START:  op_in.kind = OP_START;
			CMD_TEXT:   op_in.kind = OP_TEXT;
		endcase
	end

	assign s_axis_tready = (cnt_q != QCW'(QDEPTH));
	assign push          = s_axis_tvalid & s_axis_tready;
	assign op_valid      = (cnt_q != '0);
	assign op            = q_mem[rd_ptr_q];

	// Queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			if (op_pop)
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			case ({push, op_pop})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= op_in;
	end

	`RDSM_ASSERT_ALWAYS(a_q_bound, clk, arst_n, cnt_q <= QCW'(QDEPTH), "queue overfilled")
	`RDSM_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, op_pop, cnt_q != '0, "pop from empty queue")
	`RDSM_ASSERT_NEXT(a_q_fill, clk, arst_n, push && !op_pop && cnt_q == QCW'(QDEPTH - 1), cnt_q == QCW'(QDEPTH), "queue count lost a push")

endmodule

// ===== rtl/rdsm_back.sv =====
// Back end: pattern store, bit-parallel NFA update, result stage and output register.
// Depends on rdsm_pkg and the assertion macros header.
`include "regex_dot_star_matcher_macros.svh"

module rdsm_back import rdsm_pkg::*; #(
	parameter int MAX_ATOMS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  op_t                  op,
	input  logic                 op_valid,
	output logic                 op_pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata  // [0] whole_match, [1] no_match_possible, [2] pattern_full
);

	localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int CW = $clog2(MAX_ATOMS + 1);
	localparam int NP = MAX_ATOMS + 1;

	logic [7:0]           lit_q [MAX_ATOMS];
	logic [MAX_ATOMS-1:0] any_q, rep_q;
	logic [CW-1:0]        count_q;
	logic [NP-1:0]        active_q;
	logic                 valid_s1, full_s1;
	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic [MAX_ATOMS-1:0] lane_en, rep_m, prop_in, hit, stay, adv;
	logic [NP-1:0]        sum, carry, closed, next_set;
	logic                 has_room, whole, none, out_load, exec;

	// Per-position lanes: live atoms and byte match
	for (genvar j = 0; j < MAX_ATOMS; j++) begin : g_lane
		assign lane_en[j] = (CW'(j) < count_q);
		assign rep_m[j]   = rep_q[j] & lane_en[j];
		assign hit[j]     = lane_en[j] & closed[j] & (any_q[j] | (lit_q[j] == op.symbol));
	end

	// Closure over repeat atoms as a carry chain: generate = active & repeat, propagate = repeat
	assign prop_in = active_q[MAX_ATOMS-1:0] & rep_m;
	assign sum     = {1'b0, prop_in} + {1'b0, rep_m};
	assign carry   = sum ^ {1'b0, prop_in ^ rep_m};
	assign closed  = active_q | carry;

	// Step on a text byte: repeat atoms stay, others advance
	assign stay     = hit & rep_q;
	assign adv      = hit & ~rep_q;
	assign next_set = {1'b0, stay} | {adv, 1'b0};

	// Flags of the item in the result stage
	assign whole    = closed[count_q];
	assign none     = (closed == '0);
	assign has_room = (count_q < CW'(MAX_ATOMS));

	// Flow: result stage drains into the output register, a new item executes behind it
	assign out_load = valid_s1 & (~out_valid_q | m_axis_tready);
	assign exec     = op_valid & (~valid_s1 | out_load);
	assign op_pop   = exec;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			active_q    <= NP'(1);
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				unique case (op.kind)
					OP_CLEAR: begin
						count_q  <= '0;
						active_q <= NP'(1);
					end
					OP_APPEND: begin
						if (has_room)
							count_q <= count_q + CW'(1);
					end
					OP_START: active_q <= NP'(1);
					OP_TEXT:  active_q <= next_set;
				endcase
			end
			if (exec)
				valid_s1 <= 1'b1;
			else if (out_load)
				valid_s1 <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Pattern store and result payload
	always_ff @(posedge clk) begin
		if (exec && op.kind == OP_APPEND && has_room) begin
			lit_q[count_q[AW-1:0]] <= op.symbol;
			any_q[count_q[AW-1:0]] <= op.any_byte;
			rep_q[count_q[AW-1:0]] <= op.repeat_req;
		end
		if (exec)
			full_s1 <= (op.kind == OP_APPEND) & ~has_room;
		if (out_load)
			out_data_q <= M_TDATA_W'({full_s1, none, whole});
	end

	`RDSM_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(MAX_ATOMS), "atom count beyond capacity")
	`RDSM_ASSERT_ALWAYS(a_active_range, clk, arst_n, ((active_q >> count_q) >> 1) == '0, "active position past accepting position")
	`RDSM_ASSERT_IMPL(a_full_flag, clk, arst_n, valid_s1 && full_s1, count_q == CW'(MAX_ATOMS), "refused append while store not full")

endmodule

// ===== rtl/regex_dot_star_matcher.sv =====
// Top level of the dot-star regular expression matcher.
// Instantiates rdsm_front and rdsm_back; depends on rdsm_pkg.
//
// Usage:
//   Input stream s_axis: tuser carries the command (clear pattern, append atom,
//   start new text, text byte), tdata the symbol and the append flags.
//   Load a pattern with one append per atom, then send start and one text
//   byte per item. Every item gives exactly one result on m_axis: whole-string
//   match so far, no match possible any more, and refused append.
//   A result passes through the queue, the result stage and the output register.
//   Throughput: one item per cycle while m_axis_tready is high. Each cycle the back end closes the active
//   set over repeat atoms with one carry chain of MAX_ATOMS+1 bits and runs
//   the per-atom byte compares; that path sets the clock.
//   A two-entry queue separates decode from execution, and an output
//   register holds a result while the receiver stalls; with m_axis_tready
//   low the queue fills and s_axis_tready drops, no item is lost.
//   Reset: empty pattern, text restarted, queue and output empty. No clearing
//   pass is needed; atoms past the stored count are never looked at.
//   MAX_ATOMS sets the pattern capacity (1 to 63).
module regex_dot_star_matcher import rdsm_pkg::*; #(
	parameter int MAX_ATOMS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] symbol, [8] any_byte, [9] repeat_req
	input  logic [S_TUSER_W-1:0] s_axis_tuser,  // [1:0] command
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata   // [0] whole_match, [1] no_match_possible, [2] pattern_full
);

	op_t  op;
	logic op_valid;
	logic op_pop;

	rdsm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.op            (op),
		.op_valid      (op_valid),
		.op_pop        (op_pop)
	);

	rdsm_back #(
		.MAX_ATOMS (MAX_ATOMS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.op_valid      (op_valid),
		.op_pop        (op_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
